[rtl/lzw_variable_width_encoder_top_macros.svh]
// Assertion macros shared by the encoder checker.
`ifndef LZW_VARIABLE_WIDTH_ENCODER_TOP_MACROS_SVH
`define LZW_VARIABLE_WIDTH_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LZWVE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZWVE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define LZWVE_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/lzwve_pkg.sv]
// Constants and shared types for the LZW variable width encoder.
package lzwve_pkg;

   localparam int CODE_W      = 14;
   localparam int BITS_W      = 4;
   localparam int BYTE_W      = 8;
   localparam int FIRST_ENTRY = 256;
   localparam int START_WIDTH = 9;
   localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

   typedef struct packed {
      logic slot_rd;
      logic ent_rd;
      logic slot_wr;
      logic ent_wr;
   } mem_ctrl_type;

endpackage

[rtl/lzwve_mem.sv]
// Hash slot table and dictionary entry store, registered reads.
module lzwve_mem #(
   parameter int CW = 14,
   parameter int HB = 15
) (
   input  logic                   clock,
   input  lzwve_pkg::mem_ctrl_type ctrl,
   input  logic [HB-1:0]          slot_addr,
   input  logic [CW-1:0]          slot_wdata,
   output logic [CW-1:0]          slot_rdata,
   input  logic [CW-1:0]          ent_addr,
   input  logic [CW+7+HB:0]       ent_wdata,
   output logic [CW+7+HB:0]       ent_rdata
);
   import lzwve_pkg::*;

   localparam int SLOTS   = 1 << HB;
   localparam int ENTRIES = 1 << CW;

   logic [CW-1:0]    slot_mem [SLOTS];
   logic [CW+7+HB:0] ent_mem  [ENTRIES];

   always_ff @(posedge clock) begin
      if (ctrl.slot_wr) begin
         slot_mem[slot_addr] <= slot_wdata;
      end
      if (ctrl.slot_rd) begin
         slot_rdata <= slot_mem[slot_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ent_wr) begin
         ent_mem[ent_addr] <= ent_wdata;
      end
      if (ctrl.ent_rd) begin
         ent_rdata <= ent_mem[ent_addr];
      end
   end

endmodule

[rtl/lzw_variable_width_encoder_top.sv]
// LZW encoder top level: probe sequencer, code width tracking, result register.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_ready  req_in_byte[7:0], req_in_last
//   rsp      out  rsp_valid/rsp_ready  rsp_code[13:0], rsp_code_bits[3:0], rsp_out_last
//
// After reset a clearing pass writes every hash slot once, with req_ready low meanwhile.
// A byte that extends or breaks a string holds req_ready low through the steps hash, slot
// read, entry read and compare, the last three again per hash collision; a first byte that
// is not last takes none. The emit step registers each beat once the previous one is taken.
// Entries are qualified by the entry count and a back-pointer to their slot, so end of
// stream leaves the memories as they are.
module lzw_variable_width_encoder_top #(
   parameter int DICT_ENTRIES = 16384,
   parameter int HASH_SLOTS   = 32768
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lzwve_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                            req_in_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lzwve_pkg::CODE_W-1:0]    rsp_code,
   output logic [lzwve_pkg::BITS_W-1:0]    rsp_code_bits,
   output logic                            rsp_out_last
);
   import lzwve_pkg::*;

   localparam int CW = $clog2(DICT_ENTRIES);
   localparam int HB = $clog2(HASH_SLOTS);
   localparam logic [CW:0]   FIRST_CNT  = (CW+1)'(FIRST_ENTRY);
   localparam logic [CW:0]   DICT_CNT   = (CW+1)'(DICT_ENTRIES);
   localparam logic [HB:0]   LAST_PROBE = (HB+1)'(HASH_SLOTS - 1);
   localparam logic [HB-1:0] LAST_SLOT  = HB'(HASH_SLOTS - 1);
   localparam logic [HB-1:0] HASH_K     = HASH_MULT[HB-1:0];

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_RD_SLOT, S_RD_ENT, S_CMP, S_EMIT
   } state_type;

   state_type       state_ff;
   logic [7:0]      byte_ff;
   logic            last_ff;
   logic [CW-1:0]   prefix_ff;
   logic            prefix_valid_ff;
   logic [CW:0]     count_ff;
   logic [3:0]      width_ff;
   logic [CW:0]     thr_ff;
   logic [HB-1:0]   slot_ff;
   logic [HB:0]     probe_ff;
   logic [CW-1:0]   emit_code_ff;
   logic            emit_last_ff;
   logic            flush_ff;
   logic            widened_ff;
   logic            rsp_valid_ff;
   logic [CODE_W-1:0] rsp_code_ff;
   logic [BITS_W-1:0] rsp_bits_ff;
   logic            rsp_last_ff;

   mem_ctrl_type    ctrl;
   logic [CW-1:0]   slot_rdata;
   logic [CW+7+HB:0] ent_rdata;
   logic [CW-1:0]   ent_addr;
   logic [CW-1:0]   idx;
   logic [CW-1:0]   ent_prefix;
   logic [7:0]      ent_suffix;
   logic [HB-1:0]   ent_slot;
   logic            slot_live;
   logic            slot_hit;
   logic            can_insert;
   logic            out_free;
   logic            widen;
   logic [CW+HB+7:0] key_ext;
   logic [2*HB-1:0] hash_prod;
   logic [CW+CODE_W-1:0] code_ext;
   logic [CW+CODE_W:0]   thr_ext;

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_code      = rsp_code_ff;
   assign rsp_code_bits = rsp_bits_ff;
   assign rsp_out_last  = rsp_last_ff;

   // Only the low HB bits of key * multiplier reach the slot number.
   assign key_ext   = {{HB{1'b0}}, prefix_ff, byte_ff};
   assign hash_prod = key_ext[HB-1:0] * HASH_K;

   assign idx        = slot_rdata;
   assign ent_prefix = ent_rdata[CW+7+HB:8+HB];
   assign ent_suffix = ent_rdata[7+HB:HB];
   assign ent_slot   = ent_rdata[HB-1:0];
   assign ent_addr   = ctrl.ent_wr ? count_ff[CW-1:0] : idx;

   // A slot is live only if it names an entry of this stream that points back at it.
   always_comb begin
      slot_live  = ({1'b0, idx} >= FIRST_CNT) && ({1'b0, idx} < count_ff)
                   && (ent_slot == slot_ff);
      slot_hit   = slot_live && (ent_prefix == prefix_ff) && (ent_suffix == byte_ff);
      can_insert = (count_ff < DICT_CNT);
   end

   always_comb begin
      ctrl         = '0;
      // the clearing pass writes the first entry number, which is dead until written
      ctrl.slot_wr = (state_ff == S_CLEAR);
      ctrl.slot_rd = (state_ff == S_RD_SLOT);
      ctrl.ent_rd  = (state_ff == S_RD_ENT);
      if (state_ff == S_CMP) begin
         if (slot_hit) begin
            ctrl = '0;
         end else if (slot_live) begin
            ctrl = '0;
         end else begin
            ctrl.slot_wr = can_insert;
            ctrl.ent_wr  = can_insert;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   // at most one widen marker ahead of each code
   assign widen    = ({1'b0, emit_code_ff} >= thr_ff) && !widened_ff;
   assign code_ext = {{CODE_W{1'b0}}, emit_code_ff};
   assign thr_ext  = {{CODE_W{1'b0}}, thr_ff};

   lzwve_mem #(.CW(CW), .HB(HB)) u_mem (
      .clock      (clock),
      .ctrl       (ctrl),
      .slot_addr  (slot_ff),
      .slot_wdata (count_ff[CW-1:0]),
      .slot_rdata (slot_rdata),
      .ent_addr   (ent_addr),
      .ent_wdata  ({prefix_ff, byte_ff, slot_ff}),
      .ent_rdata  (ent_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         slot_ff         <= '0;
         prefix_valid_ff <= 1'b0;
         count_ff        <= FIRST_CNT;
         width_ff        <= 4'(START_WIDTH);
         thr_ff          <= FIRST_CNT;
         flush_ff        <= 1'b0;
         widened_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               slot_ff <= slot_ff + 1'b1;
               if (slot_ff == LAST_SLOT) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  byte_ff <= req_in_byte;
                  last_ff <= req_in_last;
                  if (!prefix_valid_ff) begin
                     prefix_ff       <= CW'(req_in_byte);
                     prefix_valid_ff <= 1'b1;
                     if (req_in_last) begin
                        emit_code_ff <= CW'(req_in_byte);
                        emit_last_ff <= 1'b1;
                        flush_ff     <= 1'b0;
                        state_ff     <= S_EMIT;
                     end
                  end else begin
                     state_ff <= S_HASH;
                  end
               end
            end
            S_HASH: begin
               slot_ff  <= hash_prod[HB-1:0];
               probe_ff <= '0;
               state_ff <= S_RD_SLOT;
            end
            S_RD_SLOT: begin
               state_ff <= S_RD_ENT;
            end
            S_RD_ENT: begin
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (slot_hit) begin
                  prefix_ff <= idx;
                  if (last_ff) begin
                     emit_code_ff <= idx;
                     emit_last_ff <= 1'b1;
                     flush_ff     <= 1'b0;
                     state_ff     <= S_EMIT;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else if (slot_live && (probe_ff != LAST_PROBE)) begin
                  // advance to the next slot of the chain
                  slot_ff  <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
                  probe_ff <= probe_ff + 1'b1;
                  state_ff <= S_RD_SLOT;
               end else begin
                  // miss: a free slot takes the new entry; a full dictionary or probe chain drops it
                  if (!slot_live && can_insert) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  emit_code_ff <= prefix_ff;
                  emit_last_ff <= 1'b0;
                  flush_ff     <= last_ff;
                  prefix_ff    <= CW'(byte_ff);
                  state_ff     <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_bits_ff  <= width_ff;
                  if (widen) begin
                     rsp_code_ff <= thr_ext[CODE_W-1:0];
                     rsp_last_ff <= 1'b0;
                     width_ff    <= width_ff + 1'b1;
                     thr_ff      <= {thr_ff[CW-1:0], 1'b0};
                     widened_ff  <= 1'b1;
                  end else begin
                     rsp_code_ff <= code_ext[CODE_W-1:0];
                     rsp_last_ff <= emit_last_ff;
                     widened_ff  <= 1'b0;
                     if (flush_ff) begin
                        emit_code_ff <= prefix_ff;
                        emit_last_ff <= 1'b1;
                        flush_ff     <= 1'b0;
                     end else begin
                        if (emit_last_ff) begin
                           // end of stream: drop the dictionary and restart
                           prefix_valid_ff <= 1'b0;
                           count_ff        <= FIRST_CNT;
                           width_ff        <= 4'(START_WIDTH);
                           thr_ff          <= FIRST_CNT;
                        end
                        state_ff <= S_IDLE;
                     end
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/lzwve_checker.sv]
// Port-level checker for the LZW encoder, bound to the top level.
`include "lzw_variable_width_encoder_top_macros.svh"

module lzwve_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [lzwve_pkg::CODE_W-1:0] rsp_code,
   input logic [lzwve_pkg::BITS_W-1:0] rsp_code_bits,
   input logic                         rsp_out_last
);
   import lzwve_pkg::*;

   `LZWVE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_code) && $stable(rsp_code_bits) && $stable(rsp_out_last), "rsp beat changed while stalled")
   `LZWVE_ASSERT_RESET(a_rsp_reset, reset, !rsp_valid, "rsp valid after reset")
   `LZWVE_ASSERT_RESET(a_req_reset, reset, !req_ready, "encoder ready during slot clearing")
   `LZWVE_ASSERT_NOW(a_req_idle, req_valid && !req_ready, !$isunknown(rsp_valid), "rsp valid unknown while busy")

endmodule

bind lzw_variable_width_encoder_top lzwve_checker u_lzwve_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_code      (rsp_code),
   .rsp_code_bits (rsp_code_bits),
   .rsp_out_last  (rsp_out_last)
);

[bench/lzw_variable_width_encoder_top_test.sv]
// Self-checking bench for the LZW variable width encoder: directed streams, then random ones.
module lzw_variable_width_encoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lzwve_pkg::*;

   localparam int DICT_SIZE   = 16384;
   localparam int SLOT_COUNT  = 32768;
   localparam int ITEM_TARGET = 310;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 60;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [CODE_W-1:0] code;
      logic [BITS_W-1:0] bits;
      logic              last;
   } code_beat_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              typed;
      logic [CODE_W-1:0] code;
      logic [BITS_W-1:0] bits;
      logic              code_last;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_in_byte;
   logic                req_in_last;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CODE_W-1:0]   rsp_code;
   logic [BITS_W-1:0]   rsp_code_bits;
   logic                rsp_out_last;

   lzw_variable_width_encoder_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_in_byte(req_in_byte), .req_in_last(req_in_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_code(rsp_code), .rsp_code_bits(rsp_code_bits), .rsp_out_last(rsp_out_last)
   );

   always #6 clock = ~clock;

   // encoder state mirror
   logic [CODE_W-1:0] dict_prefix [DICT_SIZE];
   logic [7:0]        dict_suffix [DICT_SIZE];
   int unsigned       slot_entry  [SLOT_COUNT];
   int unsigned       slot_gen    [SLOT_COUNT];
   int unsigned       stream_gen = 1;
   int unsigned       cur_prefix;
   bit                have_prefix;
   int unsigned       dict_count;
   int unsigned       code_width;
   int unsigned       widen_at;

   code_beat_type expected_codes[$];
   int          error_count = 0;
   int          beats_seen = 0;
   int          cycle_count = 0;
   int          burst_left = 0;

   task automatic report(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic int unsigned slot_hash(int unsigned prefix, int unsigned suffix);
      bit [31:0] key;
      key = ((prefix & 32'hFFFFF) << 8) | (suffix & 32'hFF);
      key = key * 32'd2654435761;
      return key % SLOT_COUNT;
   endfunction

   task automatic restart_stream();
      stream_gen++;   // invalidates every slot at once
      have_prefix = 0;
      cur_prefix  = 0;
      dict_count  = FIRST_ENTRY;
      code_width  = START_WIDTH;
      widen_at    = FIRST_ENTRY;
   endtask

   task automatic push_code(int unsigned code, int unsigned last);
      code_beat_type b;
      if (code >= widen_at) begin
         b.code = widen_at[CODE_W-1:0];
         b.bits = code_width[BITS_W-1:0];
         b.last = 1'b0;
         expected_codes.push_back(b);
         code_width++;
         widen_at = widen_at << 1;
      end
      b.code = code[CODE_W-1:0];
      b.bits = code_width[BITS_W-1:0];
      b.last = last[0];
      expected_codes.push_back(b);
   endtask

   task automatic encode_byte(input logic [7:0] data, input logic last);
      int unsigned s;
      int unsigned idx;
      bit          hit;
      hit = 0;
      if (!have_prefix) begin
         cur_prefix  = data;
         have_prefix = 1;
      end else begin
         s = slot_hash(cur_prefix, data);
         for (int n = 0; n < SLOT_COUNT; n++) begin
            if (slot_gen[s] != stream_gen) break;
            idx = slot_entry[s];
            if (idx < DICT_SIZE && dict_prefix[idx] == cur_prefix && dict_suffix[idx] == data) begin
               hit = 1;
               break;
            end
            s = (s + 1) % SLOT_COUNT;
         end
         if (hit) begin
            cur_prefix = idx;
         end else begin
            push_code(cur_prefix, 0);
            if (dict_count < DICT_SIZE) begin
               s = slot_hash(cur_prefix, data);
               for (int n = 0; n < SLOT_COUNT; n++) begin
                  if (slot_gen[s] != stream_gen) begin
                     dict_prefix[dict_count] = cur_prefix[CODE_W-1:0];
                     dict_suffix[dict_count] = data;
                     slot_entry[s] = dict_count;
                     slot_gen[s]   = stream_gen;
                     dict_count++;
                     break;
                  end
                  s = (s + 1) % SLOT_COUNT;
               end
            end
            cur_prefix = data;
         end
      end
      if (last) begin
         push_code(cur_prefix, 1);
         restart_stream();
      end
   endtask

   // offer one beat and predict on acceptance
   task automatic offer_byte(input logic [7:0] data, input logic last);
      req_valid   <= 1'b1;
      req_in_byte <= data;
      req_in_last <= last;
      do @(posedge clock); while (!req_ready);
      encode_byte(data, last);
   endtask

   // keep the burst pattern going after an accepted beat
   task automatic burst_gap();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_byte(input logic [7:0] data, input logic last);
      offer_byte(data, last);
      burst_gap();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_codes.size() != 0);
   endtask

   dir_row_type dir_rows [15] = '{
      '{8'h00, 1'b1, 1'b1, 14'd0,   4'd9, 1'b1},
      '{8'hFF, 1'b1, 1'b1, 14'd255, 4'd9, 1'b1},
      '{8'h41, 1'b0, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'h41, 1'b0, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'h41, 1'b0, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'h41, 1'b1, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'h00, 1'b1, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'hAA, 1'b0, 1'b0, 14'd0, 4'd0, 1'b0},
      '{8'h55, 1'b1, 1'b0, 14'd0, 4'd0, 1'b0}
   };

   initial begin
      int          mark;
      int          sent;
      int          len;
      int          base;
      int          span;
      bit          noisy;
      logic [7:0]  data;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_in_byte <= '0;
      req_in_last <= 1'b0;
      restart_stream();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].typed) begin
            // empty the queue so the row's codes can be checked in place
            if (expected_codes.size() != 0) wait_drained();
            mark = expected_codes.size();
            offer_byte(dir_rows[i].data, dir_rows[i].last);
            if (expected_codes.size() != mark + 1 ||
                expected_codes[mark].code != dir_rows[i].code ||
                expected_codes[mark].bits != dir_rows[i].bits ||
                expected_codes[mark].last != dir_rows[i].code_last)
               report($sformatf("predictor disagrees with directed row %0d", i));
            while (expected_codes.size() > mark) void'(expected_codes.pop_back());
            expected_codes.push_back('{dir_rows[i].code, dir_rows[i].bits,
                                       dir_rows[i].code_last});
            burst_gap();
         end else begin
            send_byte(dir_rows[i].data, dir_rows[i].last);
         end
      end
      wait_drained();

      // mostly small alphabets so strings grow; some full-range noise
      sent = 0;
      while (sent < ITEM_TARGET) begin
         noisy = ($urandom_range(0, 4) == 0);
         len   = $urandom_range(0, 9) == 0 ? $urandom_range(40, 90) : $urandom_range(1, 25);
         base  = $urandom_range(0, 255);
         span  = $urandom_range(0, 3);
         for (int k = 0; k < len; k++) begin
            data = noisy ? 8'($urandom_range(0, 255)) : 8'(base + $urandom_range(0, span));
            send_byte(data, k == len - 1);
            sent++;
         end
      end
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: phased stall pattern plus one long hold-off
   initial begin
      int hold_left;
      int phase_left;
      int stall_pct;
      bit held;
      hold_left  = 0;
      phase_left = 0;
      stall_pct  = 0;
      held       = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held && beats_seen >= 40) begin
            held      = 1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(5, 60);
               case ($urandom_range(0, 2))
                  0: stall_pct = 0;
                  1: stall_pct = 30;
                  default: stall_pct = 75;
               endcase
            end
            phase_left--;
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      code_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (expected_codes.size() == 0) begin
            report($sformatf("unexpected code %0d", rsp_code));
         end else begin
            want = expected_codes.pop_front();
            if (rsp_code !== want.code)
               report($sformatf("code %0d, want %0d", rsp_code, want.code));
            if (rsp_code_bits !== want.bits)
               report($sformatf("code_bits %0d, want %0d", rsp_code_bits, want.bits));
            if (rsp_out_last !== want.last)
               report($sformatf("out_last %0b, want %0b", rsp_out_last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d codes outstanding", expected_codes.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
